// File: design/mprc_pkg.sv
// ----------------------------------------------------------------------------
// MED predictor residual coder package
// Shared sizes, register map, config and result types, and the median edge
// detector function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mprc_pkg;

  // Plane size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 12;
  localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = (SIZE_W > CNT_W + 1) ? SIZE_W : CNT_W + 1;

  localparam int PIX_W  = 8;
  localparam int DATA_W = 9;

  // Register file
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DIRECTION    = 2'd0,
    REG_PLANE_WIDTH  = 2'd1,
    REG_PLANE_HEIGHT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  localparam logic [SIZE_W-1:0] RST_PLANE_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_PLANE_HEIGHT = SIZE_W'(480);

  typedef struct packed {
    dir_e              direction;
    logic [SIZE_W-1:0] plane_width;
    logic [SIZE_W-1:0] plane_height;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     plane_end;
  } res_t;

  // Map a size register to the range 1..maxv
  function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                 input logic [CMP_W-1:0]  maxv);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (v == '0) begin
      return CMP_W'(1);
    end
    if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  // Median edge detector: a = left, b = up, c = up-left
  function automatic logic [PIX_W-1:0] med_predict(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    mx = (a > b) ? a : b;
    mn = (a > b) ? b : a;
    if (c >= mx) begin
      return mn;
    end
    if (c <= mn) begin
      return mx;
    end
    return PIX_W'(a + b - c);
  endfunction

endpackage

// File: design/mprc_ram.sv
// ----------------------------------------------------------------------------
// MPRC generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mprc_cfg_regs.sv
// ----------------------------------------------------------------------------
// MPRC configuration registers
// APB-style register file for direction and plane size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mprc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mprc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mprc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mprc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mprc_pkg::cfg_t                 cfg_o
);

  import mprc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction    <= DIR_ENCODE;
      cfg_q.plane_width  <= RST_PLANE_WIDTH;
      cfg_q.plane_height <= RST_PLANE_HEIGHT;
    end else if (wr_en) begin
      unique case (idx)
        REG_DIRECTION:    cfg_q.direction    <= dir_e'(pwdata[0]);
        REG_PLANE_WIDTH:  cfg_q.plane_width  <= pwdata[SIZE_W-1:0];
        REG_PLANE_HEIGHT: cfg_q.plane_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIRECTION:    prdata = PDATA_W'(cfg_q.direction);
      REG_PLANE_WIDTH:  prdata = PDATA_W'(cfg_q.plane_width);
      REG_PLANE_HEIGHT: prdata = PDATA_W'(cfg_q.plane_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/mprc_predictor.sv
// ----------------------------------------------------------------------------
// MPRC predictor datapath
// Raster counters, neighbor registers, line store and MED residual logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mprc_predictor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mprc_pkg::cfg_t                       cfg_i,
  input  logic                                 accept_i,
  input  logic signed [mprc_pkg::DATA_W-1:0]   data_in_i,
  output mprc_pkg::res_t                       res_o
);

  import mprc_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] left_q, upleft_q;
  logic             byp_q;
  logic [PIX_W-1:0] byp_data_q;

  logic [CMP_W-1:0] width_eff, height_eff;
  logic             last_col, last_row;
  logic [COL_W-1:0] col_next;
  logic [COL_W-1:0] raddr;
  logic [PIX_W-1:0] ram_rdata, up_raw;
  logic [PIX_W-1:0] a, b, c, pred, pixel;
  logic [DATA_W-1:0] result;

  assign width_eff  = clamp_size(cfg_i.plane_width, CMP_W'(MAX_WIDTH));
  assign height_eff = clamp_size(cfg_i.plane_height, CMP_W'(MAX_HEIGHT));
  assign last_col   = CMP_W'(col_q) >= (width_eff - CMP_W'(1));
  assign last_row   = CMP_W'(row_q) >= (height_eff - CMP_W'(1));

  assign col_next = last_col ? '0 : COL_W'(col_q + COL_W'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      col_d = col_next;
      if (last_col) begin
        row_d = last_row ? '0 : ROW_W'(row_q + ROW_W'(1));
      end
    end
  end

  // Prefetch the up neighbor of the next word
  assign raddr = col_d;

  mprc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (accept_i),
    .waddr_i(col_q),
    .wdata_i(pixel),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Forward a pixel written at the address read in the same cycle
  assign up_raw = byp_q ? byp_data_q : ram_rdata;

  assign a    = (col_q == '0) ? '0 : left_q;
  assign b    = (row_q == '0) ? '0 : up_raw;
  assign c    = (col_q == '0 || row_q == '0) ? '0 : upleft_q;
  assign pred = med_predict(a, b, c);

  always_comb begin
    unique case (cfg_i.direction)
      DIR_ENCODE: begin
        pixel  = data_in_i[PIX_W-1:0];
        result = DATA_W'({1'b0, pixel} - {1'b0, pred});
      end
      DIR_DECODE: begin
        pixel  = PIX_W'(data_in_i[PIX_W-1:0] + pred);
        result = DATA_W'({1'b0, pixel});
      end
      default: begin
        pixel  = '0;
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      upleft_q <= '0;
      byp_q    <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      byp_q <= accept_i && (raddr == col_q);
      if (accept_i) begin
        left_q   <= pixel;
        upleft_q <= b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= pixel;
  end

  assign res_o.data_out  = signed'(result);
  assign res_o.plane_end = last_col && last_row;

`ifndef NO_ASSERTIONS
  a_byp_only_col0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> col_q == '0)
    else $error("line store forward outside column zero");

  a_plane_end_wraps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.plane_end |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after last word of plane");

  a_neighbors_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(left_q) && $stable(col_q) && $stable(row_q))
    else $error("predictor state moved without an accepted word");
`endif

endmodule

// File: design/mprc_out_skid.sv
// ----------------------------------------------------------------------------
// MPRC output skid buffer
// Result register plus one skid entry so input flow survives output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mprc_out_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mprc_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mprc_pkg::res_t res_o
);

  import mprc_pkg::*;

  logic main_vld_q, skid_vld_q;
  res_t main_q, skid_q;
  logic main_free;

  assign main_free = !main_vld_q || !out_stall_i;
  assign full_o    = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (main_free) begin
      main_vld_q <= skid_vld_q || push_i;
      skid_vld_q <= 1'b0;
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_vld_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = main_vld_q;
  assign res_o       = main_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held without result register");

  a_skid_fill_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(main_vld_q && out_stall_i && push_i))
    else $error("skid entry filled while result register was free");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("word pushed into full output buffer");
`endif

endmodule

// File: design/med_predictor_residual_coder_top.sv
// ----------------------------------------------------------------------------
// MED predictor residual coder, top level
// Output: an accepted word's result is registered in the output skid buffer.
// Throughput: one word per clock while the skid entry is free; the line store
//   read for the next word is issued while the current one is accepted, so its
//   single read port is used once per word.
// Reset: counters, neighbors and output valid clear at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Samples arrive in raster order. Each word is predicted from its left, up and
// up-left neighbors with the median edge detector:
//   - encode: data_out = sample - prediction (9-bit two's complement)
//   - decode: data_out = (residue + prediction) mod 256
// The stored pixel (sample or reconstruction) feeds later predictions.
// plane_end marks the last column of the last row; counters then wrap.
//
// Register map (32-bit, byte addresses):
//   0x0 direction    0 encode, 1 decode
//   0x4 plane_width  columns, 0 acts as 1, values above the maximum saturate
//   0x8 plane_height rows, same rules
// Write the registers only while the block is idle.

module med_predictor_residual_coder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mprc_pkg::DATA_W-1:0]   data_in_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mprc_pkg::DATA_W-1:0]   data_out_o,
  output logic                                 plane_end_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mprc_pkg::PADDR_W-1:0]         paddr,
  input  logic [mprc_pkg::PDATA_W-1:0]         pwdata,
  output logic [mprc_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  import mprc_pkg::*;

  cfg_t cfg;
  res_t res_comb;
  res_t res_out;
  logic accept;
  logic buf_full;

  // Stall upstream only when the skid entry is occupied
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  mprc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Single pass: counters, neighbors and line store advance on each word
  mprc_predictor u_predictor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .data_in_i(data_in_i),
    .res_o    (res_comb)
  );

  // Hold results here while the output side stalls
  mprc_out_skid u_out_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res_comb),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign data_out_o  = res_out.data_out;
  assign plane_end_o = res_out.plane_end;

endmodule
